/* hw/rtl/mwd_pkg.sv */
`timescale 1ns / 1ps

package mwd_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ACC_W    = 48;
  localparam int unsigned SUM_W    = 56;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned IDX_W    = 16;

  localparam int unsigned DECAY_W  = 25;
  localparam int unsigned DWIN_W   = 10;
  localparam int unsigned AWIN_W   = 9;
  localparam int unsigned RCP_W    = 25;
  localparam int unsigned CFG_W    = 25;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DEF_MAX_DIFF_WINDOW = 512;
  localparam int unsigned DEF_MAX_AVG_WINDOW  = 256;
  localparam int unsigned DEF_SAMPLE_BITS     = 16;
  localparam int unsigned DEF_FRAC_BITS       = 24;

  localparam logic [DECAY_W-1:0] DECAY_RST = DECAY_W'(16776309);
  localparam logic [DWIN_W-1:0]  DWIN_RST  = DWIN_W'(400);
  localparam logic [AWIN_W-1:0]  AWIN_RST  = AWIN_W'(200);
  localparam logic [RCP_W-1:0]   RCP_RST   = RCP_W'(83886);

  localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEFF    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_WINDOW     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_RECIPROCAL = 2'd3;

endpackage

/* hw/rtl/mwd_ram.sv */
`timescale 1ns / 1ps

module mwd_ram #(
  parameter int unsigned DEPTH = mwd_pkg::DEF_MAX_DIFF_WINDOW,
  parameter int unsigned WIDTH = mwd_pkg::ACC_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  import mwd_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/moving_window_deconvolution.sv */
`timescale 1ns / 1ps
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: sample; tuser: trace_start
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: mwd_value, sample_index;
//                                                   tuser: averaged
// cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// one transaction runs through the steps accept, decay multiply and history reads, accumulate,
// difference, running sum, split average multiply, output load.
// a new sample is accepted only in the idle step, after the previous result is loaded for output.
// the output register holds a finished result while the next sample is accepted.
// a stalled output holds the sequencer in its last step; reset clears the sequencer,
// configuration, trace state and output valid, but not the datapath or history memories.

module moving_window_deconvolution #(
  parameter int unsigned MAX_DIFF_WINDOW = mwd_pkg::DEF_MAX_DIFF_WINDOW,
  parameter int unsigned MAX_AVG_WINDOW  = mwd_pkg::DEF_MAX_AVG_WINDOW,
  parameter int unsigned SAMPLE_BITS     = mwd_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned FRAC_BITS       = mwd_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mwd_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // [15:0] sample
  input  logic [0:0]                      s_axis_tuser,  // [0] trace_start
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mwd_pkg::OUT_W+mwd_pkg::IDX_W-1:0] m_axis_tdata,
                                          // [31:0] mwd_value, [47:32] sample_index
  output logic [0:0]                      m_axis_tuser,  // [0] averaged
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mwd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mwd_pkg::CFG_W-1:0]       cfg_data_i
);

  import mwd_pkg::*;

  localparam int unsigned DAW    = $clog2(MAX_DIFF_WINDOW);
  localparam int unsigned LAW    = $clog2(MAX_AVG_WINDOW);
  localparam int unsigned MW     = $clog2(MAX_DIFF_WINDOW + 1);
  localparam int unsigned LW     = $clog2(MAX_AVG_WINDOW + 1);
  localparam int unsigned PROD_W = SAMPLE_BITS + DECAY_W + 1;
  localparam int unsigned LO_W   = SUM_W / 2;
  localparam int unsigned HI_W   = SUM_W - LO_W;
  localparam int unsigned PLO_W  = LO_W + RCP_W;
  localparam int unsigned PHI_W  = HI_W + RCP_W + 1;
  localparam int unsigned FULL_W = SUM_W + RCP_W + 1;
  localparam int unsigned SH_D   = FRAC_BITS - 8;
  localparam int unsigned SH_A   = 2 * FRAC_BITS - 8;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_DIFF = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_PROD = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] state_q, state_d;

  logic [DECAY_W-1:0] decay_q;
  logic [DWIN_W-1:0]  dwin_q;
  logic [AWIN_W-1:0]  awin_q;
  logic [RCP_W-1:0]   rcp_q;

  logic [SAMPLE_BITS-1:0]   prev_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [IDX_W-1:0]         pos_q;
  logic [DAW-1:0]           wp_q;
  logic [LAW-1:0]           ap_q;

  logic [SAMPLE_W-1:0]      x_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  d_q;
  logic [PLO_W-1:0]         plo_q;
  logic signed [PHI_W-1:0]  phi_q;

  logic                     out_valid_q;
  logic [OUT_W-1:0]         out_value_q;
  logic [IDX_W-1:0]         out_index_q;
  logic                     out_avg_q;

  logic [MW-1:0]            m_win;
  logic [LW-1:0]            l_win;
  logic [DAW:0]             ard_t;
  logic [DAW-1:0]           ard_addr;
  logic [LAW:0]             drd_t;
  logic [LAW-1:0]           drd_addr;
  logic [ACC_W-1:0]         ard_rdata;
  logic [ACC_W-1:0]         drd_rdata;

  logic signed [ACC_W-1:0]  x_ext;
  logic signed [ACC_W-1:0]  a_new;
  logic signed [ACC_W-1:0]  d_new;
  logic signed [SUM_W-1:0]  old_d;
  logic                     pos_ge_m;
  logic                     pos_ge_l;
  logic                     avg;
  logic signed [FULL_W-1:0] full_prod;
  logic signed [FULL_W-1:0] d_full;
  logic signed [FULL_W-1:0] shifted;
  logic [OUT_W-1:0]         sat_value;
  logic                     accept;
  logic                     out_load;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  // window clamps
  always_comb begin
    if (dwin_q == '0) begin
      m_win = MW'(1);
    end else if (16'(dwin_q) > 16'(MAX_DIFF_WINDOW)) begin
      m_win = MW'(MAX_DIFF_WINDOW);
    end else begin
      m_win = MW'(dwin_q);
    end
    if (awin_q == '0) begin
      l_win = LW'(1);
    end else if (16'(awin_q) > 16'(MAX_AVG_WINDOW)) begin
      l_win = LW'(MAX_AVG_WINDOW);
    end else begin
      l_win = LW'(awin_q);
    end
  end

  // history read addresses
  always_comb begin
    ard_t = {1'b0, wp_q} + (DAW+1)'(MAX_DIFF_WINDOW) - (DAW+1)'(m_win);
    if (ard_t >= (DAW+1)'(MAX_DIFF_WINDOW)) begin
      ard_t = ard_t - (DAW+1)'(MAX_DIFF_WINDOW);
    end
    ard_addr = ard_t[DAW-1:0];
    drd_t = {1'b0, ap_q} + (LAW+1)'(MAX_AVG_WINDOW) - (LAW+1)'(l_win);
    if (drd_t >= (LAW+1)'(MAX_AVG_WINDOW)) begin
      drd_t = drd_t - (LAW+1)'(MAX_AVG_WINDOW);
    end
    drd_addr = drd_t[LAW-1:0];
  end

  assign pos_ge_m = {1'b0, pos_q} >= 17'(m_win);
  assign pos_ge_l = {1'b0, pos_q} >= 17'(l_win);
  assign avg      = ({1'b0, pos_q} + 17'd1) >= 17'(l_win);

  assign x_ext = ACC_W'($signed(x_q[SAMPLE_BITS-1:0]));
  assign a_new = acc_q + (x_ext <<< FRAC_BITS) - ACC_W'(prod_q);
  assign d_new = pos_ge_m ? (acc_q - $signed(ard_rdata)) : acc_q;
  assign old_d = pos_ge_l ? SUM_W'($signed(drd_rdata)) : '0;

  // output scaling, floor rounding and saturation
  always_comb begin
    full_prod = (FULL_W'(phi_q) <<< LO_W) + $signed(FULL_W'(plo_q));
    d_full    = FULL_W'(d_q);
    shifted   = avg ? (full_prod >>> SH_A) : (d_full >>> SH_D);
    if ((&shifted[FULL_W-1:OUT_W-1]) || !(|shifted[FULL_W-1:OUT_W-1])) begin
      sat_value = shifted[OUT_W-1:0];
    end else if (shifted[FULL_W-1]) begin
      sat_value = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  mwd_ram #(
    .DEPTH (MAX_DIFF_WINDOW),
    .WIDTH (ACC_W)
  ) u_accum_hist (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_ACC),
    .waddr_i (wp_q),
    .wdata_i (a_new),
    .re_i    (state_q == ST_MUL),
    .raddr_i (ard_addr),
    .rdata_o (ard_rdata)
  );

  mwd_ram #(
    .DEPTH (MAX_AVG_WINDOW),
    .WIDTH (ACC_W)
  ) u_diff_hist (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_DIFF),
    .waddr_i (ap_q),
    .wdata_i (d_new),
    .re_i    (state_q == ST_MUL),
    .raddr_i (drd_addr),
    .rdata_o (drd_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = ST_DIFF;
      ST_DIFF: state_d = ST_SUM;
      ST_SUM:  state_d = ST_PROD;
      ST_PROD: state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DECAY_RST;
      dwin_q  <= DWIN_RST;
      awin_q  <= AWIN_RST;
      rcp_q   <= RCP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DECAY_COEFF:    decay_q <= cfg_data_i[DECAY_W-1:0];
        REG_DIFF_WINDOW:    dwin_q  <= cfg_data_i[DWIN_W-1:0];
        REG_AVG_WINDOW:     awin_q  <= cfg_data_i[AWIN_W-1:0];
        REG_AVG_RECIPROCAL: rcp_q   <= cfg_data_i[RCP_W-1:0];
        default: ;
      endcase
    end
  end

  // trace state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      prev_q  <= '0;
      acc_q   <= '0;
      sum_q   <= '0;
      pos_q   <= '0;
      wp_q    <= '0;
      ap_q    <= '0;
    end else begin
      state_q <= state_d;
      if (accept && s_axis_tuser[0]) begin
        prev_q <= '0;
        acc_q  <= '0;
        sum_q  <= '0;
        pos_q  <= '0;
        wp_q   <= '0;
        ap_q   <= '0;
      end
      if (state_q == ST_ACC) begin
        acc_q  <= a_new;
        prev_q <= x_q[SAMPLE_BITS-1:0];
        wp_q   <= (wp_q == DAW'(MAX_DIFF_WINDOW - 1)) ? '0 : wp_q + DAW'(1);
      end
      if (state_q == ST_DIFF) begin
        ap_q <= (ap_q == LAW'(MAX_AVG_WINDOW - 1)) ? '0 : ap_q + LAW'(1);
      end
      if (state_q == ST_SUM) begin
        sum_q <= sum_q + SUM_W'(d_q) - old_d;
      end
      if (out_load && (pos_q != {IDX_W{1'b1}})) begin
        pos_q <= pos_q + IDX_W'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= s_axis_tdata;
    end
    if (state_q == ST_MUL) begin
      prod_q <= $signed(prev_q) * $signed({1'b0, decay_q});
    end
    if (state_q == ST_DIFF) begin
      d_q <= d_new;
    end
    if (state_q == ST_PROD) begin
      plo_q <= sum_q[LO_W-1:0] * rcp_q;
      phi_q <= $signed(sum_q[SUM_W-1:LO_W]) * $signed({1'b0, rcp_q});
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= sat_value;
      out_index_q <= pos_q;
      out_avg_q   <= avg;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_index_q, out_value_q};
  assign m_axis_tuser  = out_avg_q;

endmodule

/* tb/mwd_output_checker.sv */
`timescale 1ns / 1ps

module mwd_output_checker (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_valid_i,
  input  logic                                     s_ready_i,
  input  logic [mwd_pkg::SAMPLE_W-1:0]             s_data_i,   // [15:0] sample
  input  logic [0:0]                               s_user_i,   // [0] trace_start
  input  logic                                     m_valid_i,
  input  logic                                     m_ready_i,
  input  logic [mwd_pkg::OUT_W+mwd_pkg::IDX_W-1:0] m_data_i,
                                                   // [31:0] mwd_value, [47:32] sample_index
  input  logic [0:0]                               m_user_i,   // [0] averaged
  input  logic                                     cfg_valid_i,
  input  logic                                     cfg_ready_i,
  input  logic [mwd_pkg::CFG_IDX_W-1:0]            cfg_index_i,
  input  logic [mwd_pkg::CFG_W-1:0]                cfg_data_i,
  output int                                       mismatches_o,
  output int                                       outstanding_o
);

  import mwd_pkg::*;

  localparam int unsigned DIFF_DEPTH = DEF_MAX_DIFF_WINDOW;
  localparam int unsigned AVG_DEPTH  = DEF_MAX_AVG_WINDOW;
  localparam int unsigned DPTR_W     = $clog2(DIFF_DEPTH);
  localparam int unsigned APTR_W     = $clog2(AVG_DEPTH);
  localparam int unsigned FRAC       = DEF_FRAC_BITS;
  localparam int unsigned AVG_SHIFT  = 2 * FRAC - 8;
  localparam logic signed [87:0] SAT_HI = 88'sh7FFF_FFFF;
  localparam logic signed [87:0] SAT_LO = -88'sh8000_0000;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             averaged;
    logic [IDX_W-1:0] index;
  } mwd_result_t;

  logic [DECAY_W-1:0]  decay_q;
  logic [DWIN_W-1:0]   dwin_q;
  logic [AWIN_W-1:0]   awin_q;
  logic [RCP_W-1:0]    rcp_q;

  logic [SAMPLE_W-1:0] prev_sample_q;
  logic [ACC_W-1:0]    accum_q;
  logic [SUM_W-1:0]    diff_sum_q;
  logic [IDX_W-1:0]    position_q;
  logic [DPTR_W-1:0]   accum_ptr_q;
  logic [APTR_W-1:0]   diff_ptr_q;
  logic [ACC_W-1:0]    accum_hist [DIFF_DEPTH];
  logic [ACC_W-1:0]    diff_hist  [AVG_DEPTH];

  mwd_result_t         predicted_outputs [$];
  int                  mismatch_count;
  mwd_result_t         got, want, next_result;

  assign mismatches_o = mismatch_count;

  function automatic int unsigned clamp_window(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic mwd_result_t filter_sample(input logic [SAMPLE_W-1:0] smp,
                                                input logic start);
    logic [63:0]        x64, prev64, acc64;
    logic [ACC_W-1:0]   acc_new, diff, dropped;
    logic [SUM_W-1:0]   old_diff;
    logic [DPTR_W-1:0]  accum_rd;
    logic [APTR_W-1:0]  diff_rd;
    logic signed [87:0] product, scaled;
    int unsigned        m, l;
    mwd_result_t        res;
    if (start) begin
      prev_sample_q = '0;
      accum_q       = '0;
      diff_sum_q    = '0;
      position_q    = '0;
      accum_ptr_q   = '0;
      diff_ptr_q    = '0;
    end
    m = clamp_window(dwin_q, DIFF_DEPTH);
    l = clamp_window(awin_q, AVG_DEPTH);

    // deconvolution, wraps at 48 bits
    x64     = {{(64-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
    prev64  = {{(64-SAMPLE_W){prev_sample_q[SAMPLE_W-1]}}, prev_sample_q};
    acc64   = {{(64-ACC_W){1'b0}}, accum_q} + (x64 << FRAC)
              - prev64 * {{(64-DECAY_W){1'b0}}, decay_q};
    acc_new = acc64[ACC_W-1:0];
    accum_q = acc_new;
    prev_sample_q = smp;

    // differentiation over m samples
    diff = acc_new;
    if (position_q >= m) begin
      accum_rd = accum_ptr_q - DPTR_W'(m);
      diff = acc_new - accum_hist[accum_rd];
    end
    accum_hist[accum_ptr_q] = acc_new;
    accum_ptr_q++;

    // running sum of the last l differences
    old_diff = '0;
    if (position_q >= l) begin
      diff_rd  = diff_ptr_q - APTR_W'(l);
      dropped  = diff_hist[diff_rd];
      old_diff = {{(SUM_W-ACC_W){dropped[ACC_W-1]}}, dropped};
    end
    diff_sum_q = diff_sum_q + {{(SUM_W-ACC_W){diff[ACC_W-1]}}, diff} - old_diff;
    diff_hist[diff_ptr_q] = diff;
    diff_ptr_q++;

    res.averaged = (position_q + 1 >= l);
    if (!res.averaged) begin
      // floor to q24.8, always fits in 32 bits
      res.value = diff[ACC_W-1 -: OUT_W];
    end else begin
      product = $signed({{(88-SUM_W){diff_sum_q[SUM_W-1]}}, diff_sum_q})
                * $signed({{(88-RCP_W){1'b0}}, rcp_q});
      scaled  = product >>> AVG_SHIFT;
      if (scaled > SAT_HI) res.value = 32'h7FFF_FFFF;
      else if (scaled < SAT_LO) res.value = 32'h8000_0000;
      else res.value = scaled[OUT_W-1:0];
    end
    res.index = position_q;
    if (position_q != '1) position_q++;
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] exp_val,
                        input logic [31:0] act_val);
    mismatch_count++;
    $display("%0t %s mismatch: expected %h actual %h", $time, what, exp_val, act_val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q        = DECAY_RST;
      dwin_q         = DWIN_RST;
      awin_q         = AWIN_RST;
      rcp_q          = RCP_RST;
      prev_sample_q  = '0;
      accum_q        = '0;
      diff_sum_q     = '0;
      position_q     = '0;
      accum_ptr_q    = '0;
      diff_ptr_q     = '0;
      mismatch_count = 0;
      predicted_outputs.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DECAY_COEFF:    decay_q = cfg_data_i[DECAY_W-1:0];
          REG_DIFF_WINDOW:    dwin_q  = cfg_data_i[DWIN_W-1:0];
          REG_AVG_WINDOW:     awin_q  = cfg_data_i[AWIN_W-1:0];
          REG_AVG_RECIPROCAL: rcp_q   = cfg_data_i[RCP_W-1:0];
          default: ;
        endcase
      end

      if (m_valid_i && m_ready_i) begin
        got.value    = m_data_i[OUT_W-1:0];
        got.index    = m_data_i[OUT_W+IDX_W-1:OUT_W];
        got.averaged = m_user_i[0];
        if (predicted_outputs.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected result: expected none actual value %h index %h",
                   $time, got.value, got.index);
        end else begin
          want = predicted_outputs.pop_front();
          if (got.value !== want.value) report("mwd_value", want.value, got.value);
          if (got.averaged !== want.averaged)
            report("averaged", 32'(want.averaged), 32'(got.averaged));
          if (got.index !== want.index)
            report("sample_index", 32'(want.index), 32'(got.index));
        end
      end

      if (s_valid_i && s_ready_i) begin
        next_result       = filter_sample(s_data_i, s_user_i[0]);
        predicted_outputs = {predicted_outputs, next_result};
      end

      outstanding_o <= predicted_outputs.size();
    end
  end

endmodule

/* tb/moving_window_deconvolution_test.sv */
`timescale 1ns / 1ps

module moving_window_deconvolution_test;
  import mwd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned FINAL_ITEMS  = 256;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [SAMPLE_W-1:0]      s_axis_tdata  = '0;   // [15:0] sample
  logic [0:0]               s_axis_tuser  = '0;   // [0] trace_start
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b1;
  logic [OUT_W+IDX_W-1:0]   m_axis_tdata;         // [31:0] mwd_value, [47:32] sample_index
  logic [0:0]               m_axis_tuser;         // [0] averaged
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i   = '0;
  logic [CFG_W-1:0]         cfg_data_i    = '0;

  int                       mismatches;
  int                       outstanding;
  bit                       sender_gaps     = 1'b1;
  bit                       receiver_stalls = 1'b1;

  moving_window_deconvolution dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  mwd_output_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_i     (s_axis_tready),
    .s_data_i      (s_axis_tdata),
    .s_user_i      (s_axis_tuser),
    .m_valid_i     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_i      (m_axis_tdata),
    .m_user_i      (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  // output back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic start);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_config(input logic [CFG_W-1:0] decay, input logic [CFG_W-1:0] dwin,
                             input logic [CFG_W-1:0] awin, input logic [CFG_W-1:0] rcp);
    wait_results();
    write_reg(REG_DECAY_COEFF, decay);
    write_reg(REG_DIFF_WINDOW, dwin);
    write_reg(REG_AVG_WINDOW, awin);
    write_reg(REG_AVG_RECIPROCAL, rcp);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] level);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return SAMPLE_W'($urandom);
    if (r < 6) return SAMPLE_W'($urandom_range(0, 63)) - SAMPLE_W'(32);
    if (r < 9) return level;
    return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
  endfunction

  initial begin
    int unsigned         sent, n, k;
    logic [CFG_W-1:0]    decay, dwin, awin, rcp, awin_eff;
    logic [SAMPLE_W-1:0] level;
    bit                  fresh;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, no trace start on the first sample
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b0);

    // short windows, unity decay, alternating extremes
    load_config(25'd16777216, 25'd2, 25'd3, 25'd5592406);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);

    // register change mid-trace, windows above range
    load_config(25'h1FF_FFFF, 25'd1023, 25'd511, 25'h1FF_FFFF);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);

    // zero windows and zero coefficients
    load_config(25'd0, 25'd0, 25'd0, 25'd0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       decay = 25'd0;
        1:       decay = 25'd16777216;
        2:       decay = 25'h1FF_FFFF;
        3:       decay = CFG_W'(DECAY_RST);
        default: decay = CFG_W'($urandom_range(16000000, 16777216));
      endcase
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0:       dwin = 25'd0;
          1:       dwin = 25'd1;
          2:       dwin = 25'd512;
          default: dwin = 25'd1023;
        endcase
      end else begin
        dwin = CFG_W'($urandom_range(1, 48));
      end
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0:       awin = 25'd0;
          1:       awin = 25'd1;
          2:       awin = 25'd256;
          default: awin = 25'd511;
        endcase
      end else begin
        awin = CFG_W'($urandom_range(1, 48));
      end
      awin_eff = (awin == 0) ? 25'd1 : (awin > 256) ? 25'd256 : awin;
      case ($urandom_range(0, 5))
        0:       rcp = 25'd0;
        1:       rcp = 25'h1FF_FFFF;
        2:       rcp = CFG_W'($urandom_range(0, 33554431));
        default: rcp = 25'd16777216 / awin_eff;
      endcase
      load_config(decay, dwin, awin, rcp);

      sender_gaps     = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      level           = SAMPLE_W'($urandom);
      fresh           = ($urandom_range(0, 2) != 0);
      n               = $urandom_range(40, 300);
      for (k = 0; k < n; k++)
        send_sample(pick_sample(level), (k == 0 && fresh) || $urandom_range(0, 149) == 0);
      sent += n;
    end

    // final trace, no idling
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    load_config(CFG_W'(DECAY_RST), 25'd40, 25'd32, 25'd524288);
    level = SAMPLE_W'($urandom);
    for (k = 0; k < FINAL_ITEMS; k++)
      send_sample(pick_sample(level), k == 0);

    wait_results();
    repeat (32) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mwd_pkg.sv
hw/rtl/mwd_ram.sv
hw/rtl/moving_window_deconvolution.sv
tb/mwd_output_checker.sv
tb/moving_window_deconvolution_test.sv
